/* rtl/core/firlt_pkg.sv */
// Shared types, codes and constants of the loadable-tap FIR filter.
package firlt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int GAIN_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 7;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  // Input item function codes; code 3 is ignored.
  typedef logic [1:0] func_t;
  localparam func_t FUNC_PUSH  = 2'd0;
  localparam func_t FUNC_COEF  = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TAP_COUNT  = 1'b0;
  localparam cfg_idx_t CFG_LEVEL_GAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCALE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic sweep;   // zero one coefficient slot
    logic load;    // take the input transaction
    logic scale;   // scale sample, write delay line, arm MAC
    logic issue;   // issue one tap read
    logic finish;  // round, saturate, fill output register
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic issue_last;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/fir_filter_loadable_taps.sv */
// Top level of the direct-form FIR filter with loadable coefficients.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    func, sample, coef_index, coef_value
//   output    out        out_valid / out_ready  out_sample, clipped
//   config    in         cfg_wr_en              cfg_index, cfg_wr_data
//
// A push holds in_ready low from acceptance through scale, tap walk, drain and
// result load; one shared multiply-accumulate walks the effective taps one per
// cycle through a three-stage read, multiply, add pipeline.
// Coefficient writes, history clears and unused codes leave in_ready high.
// After reset the coefficient memory is zeroed by a sweep over every slot,
// during which in_ready stays low; configuration writes are taken throughout.
// A finished result waits in the output register while the next transaction
// is accepted; only the final load of a later push waits for out_ready.
module fir_filter_loadable_taps #(
  parameter int TAPS = 128
) (
  input  logic               clk,
  input  logic               rst,
  // Input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [15:0] sample,
  input  logic [6:0]         coef_index,
  input  logic signed [17:0] coef_value,
  // Result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               clipped,
  // Configuration writes
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wr_data
);

  firlt_pkg::cmd_t    cmd;
  firlt_pkg::status_t status;

  // Sequence sweep, accept, scale, tap walk, drain and result load.
  firlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Hold the delay line as a circular buffer with a fill count, so a clear
  // drops the history at once; hold coefficients in their own memory.
  firlt_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .func        (func),
    .sample      (sample),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .clipped     (clipped)
  );

endmodule

/* rtl/core/firlt_ctrl.sv */
// Controller state machine of the loadable-tap FIR filter.
module firlt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         func,
  input  firlt_pkg::status_t status,
  output firlt_pkg::cmd_t    cmd,
  output logic               in_ready
);

  firlt_pkg::state_t state;
  firlt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= firlt_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      firlt_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = firlt_pkg::ST_IDLE;
      end
      firlt_pkg::ST_IDLE: begin
        if (in_valid && (func == firlt_pkg::FUNC_PUSH)) state_next = firlt_pkg::ST_SCALE;
      end
      firlt_pkg::ST_SCALE: begin
        state_next = firlt_pkg::ST_MAC;
      end
      firlt_pkg::ST_MAC: begin
        if (status.issue_last) state_next = firlt_pkg::ST_DRAIN;
      end
      firlt_pkg::ST_DRAIN: begin
        if (status.pipe_empty) state_next = firlt_pkg::ST_FINISH;
      end
      firlt_pkg::ST_FINISH: begin
        if (status.out_free) state_next = firlt_pkg::ST_IDLE;
      end
      default: begin
        state_next = firlt_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      firlt_pkg::ST_INIT: begin
        cmd.sweep = 1'b1;
      end
      firlt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      firlt_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      firlt_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
      end
      firlt_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      firlt_pkg::ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_init_after_reset: assert property (@(posedge clk)
    rst |=> state == firlt_pkg::ST_INIT)
    else $error("controller left reset outside the sweep state");

  a_last_issue_drains: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && status.issue_last |=> state == firlt_pkg::ST_DRAIN)
    else $error("last tap issued but pipeline not draining");

  a_finish_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == firlt_pkg::ST_IDLE)
    else $error("result loaded but controller not back to idle");

endmodule

/* rtl/core/firlt_datapath.sv */
// Datapath of the loadable-tap FIR filter: memories, shared MAC, output register.
module firlt_datapath #(
  parameter int TAPS = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  firlt_pkg::cmd_t             cmd,
  output firlt_pkg::status_t          status,
  input  logic [1:0]                  func,
  input  logic signed [15:0]          sample,
  input  logic [6:0]                  coef_index,
  input  logic signed [17:0]          coef_value,
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [15:0]                 cfg_wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_sample,
  output logic                        clipped
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW    = $clog2(TAPS + 1);
  localparam int ACC_W = firlt_pkg::PROD_W + $clog2(TAPS);
  localparam int YW    = ACC_W + 1 - 16;

  // Configuration registers.
  logic [firlt_pkg::COUNT_W-1:0] tap_count;
  logic [firlt_pkg::GAIN_W-1:0]  level_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= firlt_pkg::COUNT_W'(1);
      level_gain <= firlt_pkg::GAIN_UNITY;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        firlt_pkg::CFG_TAP_COUNT:  tap_count  <= cfg_wr_data[firlt_pkg::COUNT_W-1:0];
        firlt_pkg::CFG_LEVEL_GAIN: level_gain <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Memories.
  logic signed [firlt_pkg::SAMPLE_W-1:0] dmem [TAPS];
  logic signed [firlt_pkg::COEF_W-1:0]   cmem [TAPS];

  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] wptr;
  logic [CW-1:0] fill;
  logic [AW-1:0] daddr;
  logic [AW-1:0] caddr;
  logic [AW-1:0] k;

  logic signed [firlt_pkg::SAMPLE_W-1:0] sample_q;
  logic [firlt_pkg::GAIN_W-1:0]          gain_eff;
  logic signed [32:0]                    sprod;
  logic signed [32:0]                    srnd;
  logic signed [firlt_pkg::SAMPLE_W-1:0] scaled;
  logic [CW-1:0]                         n_eff;

  logic                 idx_ok;
  logic                 cwr_en;
  logic [AW-1:0]        cwr_addr;
  logic signed [17:0]   cwr_data;

  assign idx_ok   = 32'(coef_index) < TAPS;
  assign cwr_en   = cmd.sweep || (cmd.load && (func == firlt_pkg::FUNC_COEF) && idx_ok);
  assign cwr_addr = cmd.sweep ? sweep_addr : AW'(coef_index);
  assign cwr_data = cmd.sweep ? '0 : coef_value;

  assign gain_eff = (level_gain > firlt_pkg::GAIN_UNITY) ? firlt_pkg::GAIN_UNITY : level_gain;
  assign sprod    = 33'(sample_q) * 33'($signed({1'b0, gain_eff}));
  assign srnd     = sprod + 33'sd16384;
  assign scaled   = srnd[30:15];

  always_comb begin
    if (tap_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(tap_count) > TAPS) begin
      n_eff = CW'(TAPS);
    end else begin
      n_eff = CW'(tap_count);
    end
  end

  // Pipeline: read, multiply, accumulate.
  logic                                  v1;
  logic                                  m1;
  logic signed [firlt_pkg::SAMPLE_W-1:0] dq;
  logic signed [firlt_pkg::COEF_W-1:0]   cq;
  logic                                  v2;
  logic signed [firlt_pkg::PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]               acc;

  always_ff @(posedge clk) begin
    if (cwr_en) begin
      cmem[cwr_addr] <= cwr_data;
    end
    if (cmd.scale) begin
      dmem[wptr] <= scaled;
    end
    dq <= dmem[daddr];
    cq <= cmem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      wptr       <= '0;
      fill       <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (cmd.sweep) sweep_addr <= sweep_addr + 1'b1;
      // Drop the whole history at once; stale entries read as zero.
      if (cmd.load && (func == firlt_pkg::FUNC_CLEAR)) fill <= '0;
      if (cmd.scale) begin
        wptr <= (wptr == AW'(TAPS - 1)) ? '0 : wptr + 1'b1;
        fill <= (fill == CW'(TAPS)) ? fill : fill + 1'b1;
      end
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sample_q <= sample;
    if (cmd.scale) begin
      daddr <= wptr;
      caddr <= AW'(n_eff - 1'b1);
      k     <= '0;
      acc   <= '0;
    end
    if (cmd.issue) begin
      daddr <= (daddr == '0) ? AW'(TAPS - 1) : daddr - 1'b1;
      caddr <= caddr - 1'b1;
      k     <= k + 1'b1;
      m1    <= CW'(k) < fill;
    end
    prod <= m1 ? (firlt_pkg::PROD_W'(dq) * firlt_pkg::PROD_W'(cq)) : '0;
    if (v2) acc <= acc + ACC_W'(prod);
  end

  // Round half up, then saturate.
  logic signed [ACC_W:0]  rsum;
  logic signed [YW-1:0]   yw;
  logic                   sat_hi;
  logic                   sat_lo;

  assign rsum   = (ACC_W + 1)'(acc) + (ACC_W + 1)'(32768);
  assign yw     = rsum[ACC_W:16];
  assign sat_hi = yw > YW'(firlt_pkg::OUT_MAX);
  assign sat_lo = yw < YW'(firlt_pkg::OUT_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      clipped <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_sample <= 16'sh7fff;
      end else if (sat_lo) begin
        out_sample <= 16'sh8000;
      end else begin
        out_sample <= yw[15:0];
      end
    end
  end

  assign status.sweep_last = sweep_addr == AW'(TAPS - 1);
  assign status.issue_last = caddr == '0;
  assign status.pipe_empty = !v1 && !v2;
  assign status.out_free   = !out_valid || out_ready;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= TAPS)
    else $error("history fill count beyond delay line depth");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("product stage valid without a preceding read");

  a_clip_rails: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (out_sample == 16'sh7fff) || (out_sample == 16'sh8000))
    else $error("clipped result not at a rail");

endmodule
